// ----- hdl/symbol_rate_ratio_calc_assert.svh -----
// Assertion macros shared by the symbol rate ratio calculator.
// Each macro checks on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef SYMBOL_RATE_RATIO_CALC_ASSERT_SVH
`define SYMBOL_RATE_RATIO_CALC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("symbol rate ratio check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("symbol rate ratio check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define SRRC_ASSERT_AFTER(label, ante, n, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(n) (cons)) \
        else $error("symbol rate ratio check failed");

`endif

// ----- hdl/srrc_pkg.sv -----
package srrc_pkg;

    // Field widths.
    localparam int RATE_W = 26;
    localparam int REM_W  = 25;
    localparam int QUOT_W = 25;

    // One pipeline stage for each quotient bit.
    localparam int DIV_STAGES = QUOT_W;

    typedef logic [RATE_W-1:0] t_rate;
    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [QUOT_W-1:0] t_quot;
    typedef logic [1:0]        t_code;
    typedef logic [1:0]        t_band;

    // Clamp limits of the requested rate.
    localparam t_rate RATE_MIN = 26'd500000;
    localparam t_rate RATE_MAX = 26'd45499500;

    // Upper limits of the tuner bands (inclusive).
    localparam t_rate BAND_LIM0 = 26'd5000000;
    localparam t_rate BAND_LIM1 = 26'd15000000;

    // Rate limits of the sample clocks (exclusive).
    localparam t_rate CLK_LIM1 = 26'd22749750;
    localparam t_rate CLK_LIM2 = 26'd30333000;
    localparam t_rate CLK_LIM3 = 26'd40444000;

    // Sample clock codes.
    localparam t_code CLK_45M5 = 2'd0;
    localparam t_code CLK_60M7 = 2'd1;
    localparam t_code CLK_80M9 = 2'd2;
    localparam t_code CLK_91M0 = 2'd3;

    // Tuner band codes.
    localparam t_band BAND_LOW  = 2'd0;
    localparam t_band BAND_MID  = 2'd1;
    localparam t_band BAND_HIGH = 2'd2;

    // Word carried down the divider pipeline.
    typedef struct packed {
        t_code      code;
        t_band      band;
        logic [1:0] feed;
        t_rem       rem;
        t_quot      quot;
    } t_div_word;

    // Quarter of the chosen sample clock: the divisor of the ratio.
    function automatic t_rem quarter_of(input t_code code);
        t_rem q;
        case (code)
            CLK_45M5: q = 25'd11374875;
            CLK_60M7: q = 25'd15166500;
            CLK_80M9: q = 25'd20222000;
            default:  q = 25'd22749750;
        endcase
        return q;
    endfunction

    function automatic logic [7:0] pll_of(input t_code code);
        logic [7:0] p;
        case (code)
            CLK_60M7: p = 8'ha5;
            CLK_80M9: p = 8'h87;
            default:  p = 8'h78;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] gain_of(input t_band band);
        logic [31:0] g;
        case (band)
            BAND_LOW: g = 32'h5f8fc000;
            BAND_MID: g = 32'h580f0000;
            default:  g = 32'h500c0000;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] bw_of(input t_band band);
        logic [31:0] b;
        case (band)
            BAND_LOW: b = 32'h80f03800;
            BAND_MID: b = 32'h81f0f800;
            default:  b = 32'h83f1f800;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tune_of(input t_band band);
        logic [7:0] t;
        case (band)
            BAND_LOW: t = 8'ha2;
            BAND_MID: t = 8'hcc;
            default:  t = 8'h66;
        endcase
        return t;
    endfunction

endpackage

// ----- hdl/srrc_select.sv -----
module srrc_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  srrc_pkg::t_rate     i_rate,
    output logic                o_valid,
    output srrc_pkg::t_div_word o_word
);
    import srrc_pkg::*;

    t_rate     w_rate;
    t_band     w_band;
    t_code     w_code;
    logic      n_valid;
    t_div_word n_word;
    logic      r_valid;
    t_div_word r_word;

    // Clamp the requested rate into the supported range.
    always_comb begin
        if (i_rate > RATE_MAX) begin
            w_rate = RATE_MAX;
        end else if (i_rate < RATE_MIN) begin
            w_rate = RATE_MIN;
        end else begin
            w_rate = i_rate;
        end
    end

    // Choose the tuner band and the sample clock from the clamped rate.
    always_comb begin
        if (w_rate <= BAND_LIM0) begin
            w_band = BAND_LOW;
        end else if (w_rate <= BAND_LIM1) begin
            w_band = BAND_MID;
        end else begin
            w_band = BAND_HIGH;
        end

        if (w_rate < CLK_LIM1) begin
            w_code = CLK_45M5;
        end else if (w_rate < CLK_LIM2) begin
            w_code = CLK_60M7;
        end else if (w_rate < CLK_LIM3) begin
            w_code = CLK_80M9;
        end else begin
            w_code = CLK_91M0;
        end
    end

    // The dividend is rate shifted up by 23. Its top bits seed the remainder and
    // the two low rate bits are fed in by the first two divider steps.
    always_comb begin
        n_valid     = i_valid;
        n_word.code = w_code;
        n_word.band = w_band;
        n_word.feed = w_rate[1:0];
        n_word.rem  = {1'b0, w_rate[RATE_W-1:2]};
        n_word.quot = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- hdl/srrc_div_stage.sv -----
`include "symbol_rate_ratio_calc_assert.svh"

module srrc_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  srrc_pkg::t_div_word i_word,
    output logic                o_valid,
    output srrc_pkg::t_div_word o_word
);
    import srrc_pkg::*;

    logic [REM_W:0]   w_shift;
    logic [REM_W:0]   w_div;
    logic [REM_W+1:0] w_diff;
    logic             w_ge;
    logic             n_valid;
    t_div_word        n_word;
    logic             r_valid;
    t_div_word        r_word;

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor where it fits.
    always_comb begin
        w_shift = {i_word.rem, i_word.feed[1]};
        w_div   = {1'b0, quarter_of(i_word.code)};
        w_diff  = {1'b0, w_shift} - {1'b0, w_div};
        w_ge    = ~w_diff[REM_W+1];
    end

    always_comb begin
        n_valid     = i_valid;
        n_word.code = i_word.code;
        n_word.band = i_word.band;
        n_word.feed = {i_word.feed[0], 1'b0};
        n_word.rem  = w_ge ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];
        n_word.quot = {i_word.quot[QUOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    // The partial remainder always stays below the divisor.
    `SRRC_ASSERT_NOW(a_rem_below_divisor, r_valid, r_word.rem < quarter_of(r_word.code))

endmodule

// ----- hdl/symbol_rate_ratio_calc.sv -----
// Symbol rate ratio calculator. Each word written with start gives exactly one
// result word, shown on the result ports for one cycle while o_strobe is high.
// The accepting edge loads the clamping and band and clock selection stage, and
// each of the 25 quotient bits of the timing ratio then takes one further stage
// of a pipelined restoring divider, whose last stage drives the result ports.
// A new word may be written in every cycle, so one result leaves per cycle at
// most. The receiver cannot stall the block and must take each result in the
// cycle it appears.
// busy is high only while reset is held.
`include "symbol_rate_ratio_calc_assert.svh"

module symbol_rate_ratio_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  srrc_pkg::t_rate     i_symbol_rate,
    output logic                busy,
    output logic                o_strobe,
    output srrc_pkg::t_quot     o_rate_ratio,
    output srrc_pkg::t_code     o_clock_code,
    output logic [7:0]          o_pll_byte,
    output srrc_pkg::t_band     o_band_index,
    output logic [31:0]         o_gain_word,
    output logic [31:0]         o_bandwidth_word,
    output logic [7:0]          o_filter_tune
);
    import srrc_pkg::*;

    localparam int LATENCY = DIV_STAGES + 1;

    logic      w_accept;
    logic      w_valid [0:DIV_STAGES];
    t_div_word w_word  [0:DIV_STAGES];

    // The pipeline never holds words back, so only reset blocks a write.
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // Clamp and selection stage.
    srrc_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_rate  (i_symbol_rate),
        .o_valid (w_valid[0]),
        .o_word  (w_word[0])
    );

    // Divider chain, one quotient bit per stage.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        srrc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_word  (w_word[g]),
            .o_valid (w_valid[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    // Result word, with the band and clock tables looked up at the end.
    assign o_strobe         = w_valid[DIV_STAGES];
    assign o_rate_ratio     = w_word[DIV_STAGES].quot;
    assign o_clock_code     = w_word[DIV_STAGES].code;
    assign o_pll_byte       = pll_of(w_word[DIV_STAGES].code);
    assign o_band_index     = w_word[DIV_STAGES].band;
    assign o_gain_word      = gain_of(w_word[DIV_STAGES].band);
    assign o_bandwidth_word = bw_of(w_word[DIV_STAGES].band);
    assign o_filter_tune    = tune_of(w_word[DIV_STAGES].band);

    // Every result word follows an accepted word by the fixed latency.
    `SRRC_ASSERT_NOW(a_latency, o_strobe, $past(w_accept, LATENCY))
    // Every accepted word comes out after the fixed latency.
    `SRRC_ASSERT_AFTER(a_accept_out, w_accept, LATENCY, o_strobe)
    // The ratio never exceeds two to the twenty-fourth.
    `SRRC_ASSERT_NOW(a_ratio_range, o_strobe, o_rate_ratio <= 25'd16777216)
    // The band index stays within the three bands.
    `SRRC_ASSERT_NOW(a_band_range, o_strobe, o_band_index != 2'd3)
    // A rate in the low band always runs on the slowest sample clock.
    `SRRC_ASSERT_NOW(a_low_band_clock, o_strobe && (o_band_index == BAND_LOW),
        o_clock_code == CLK_45M5)

endmodule
